@@ hdl/dual_stepper_shift_output_assert.svh @@
// Assertion macros shared by the stepper output logic.
`ifndef DUAL_STEPPER_SHIFT_OUTPUT_ASSERT_SVH
`define DUAL_STEPPER_SHIFT_OUTPUT_ASSERT_SVH

// Check that is switched off while reset is asserted.
`define DSSO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs during reset.
`define DSSO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dsso_pkg.sv @@
`timescale 1ns / 1ps

package dsso_pkg;

  // Output image and counter sizes.
  localparam int SHIFT_BYTES = 3;
  localparam int PERIOD_BITS = 20;
  localparam int IMG_BITS    = SHIFT_BYTES * 8;
  localparam int IMG_IDX_W   = $clog2(IMG_BITS);
  localparam int OFFSET_W    = 5;
  localparam int PIN_W       = 5;
  // Bit position wide enough for an offset plus three and for any image bit.
  localparam int POS_W       = ((IMG_IDX_W > OFFSET_W) ? IMG_IDX_W : OFFSET_W) + 1;

  // Word layouts.
  localparam int IN_DATA_W   = 8;
  localparam int OUT_FIELD_W = IMG_BITS + 2;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_DATA_W  = PERIOD_BITS;
  localparam int CFG_IDX_W   = 2;

  typedef logic [IMG_BITS-1:0]    image_t;
  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [OFFSET_W-1:0]    offset_t;
  typedef logic [POS_W-1:0]       pos_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_PERIOD  = 2'd0,
    REG_RIGHT_PERIOD = 2'd1,
    REG_LEFT_OFFSET  = 2'd2,
    REG_RIGHT_OFFSET = 2'd3
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam period_t LEFT_PERIOD_RST  = PERIOD_BITS'(3000);
  localparam period_t RIGHT_PERIOD_RST = PERIOD_BITS'(6000);
  localparam offset_t LEFT_OFFSET_RST  = OFFSET_W'(8);
  localparam offset_t RIGHT_OFFSET_RST = OFFSET_W'(12);

endpackage

@@ hdl/dual_stepper_shift_output.sv @@
`timescale 1ns / 1ps
// Dual stepper wave-drive controller feeding a serial output shift register.
// Input channel (in_*): one word per microsecond tick carrying the button
// level and an optional single-pin write. Result channel (out_*): one word per
// input word with the output image after the tick, a frame-sent flag and the
// motor run flag. Config channel (cfg_*): writes the two step periods and the
// two coil bit offsets; cfg_ready is always high, and the user must make
// writes only while no word is in flight; the block does not enforce this.
// Latency: a result word is valid in the cycle after its input word is taken.
// Throughput: one word per cycle unless stalled; all tick work is a single
// combinational pass from the state registers into the state and result
// registers. Stall: the result register holds its word while out_tready is
// low, and in_tready drops until it is taken, so no word is lost or repeated.
// Reset: image, counters, phases, run flag and button latch clear, the
// configuration registers load their defaults, and the result register
// empties. Counters first come due period+1 ticks after reset; no step is made until a press sets the run flag.
`include "dual_stepper_shift_output_assert.svh"

module dual_stepper_shift_output (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input words.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] button_level, [1] pin_write_valid, [6:2] pin_index, [7] pin_level
  input  logic [dsso_pkg::IN_DATA_W-1:0]     in_tdata,
  // Result words.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [23:0] output_image, [24] frame_sent, [25] motor_enabled, rest zero
  output logic [dsso_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dsso_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsso_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam dsso_pkg::pos_t IMG_LIMIT = dsso_pkg::POS_W'(dsso_pkg::IMG_BITS);

  // Configuration registers.
  dsso_pkg::period_t left_period_r, right_period_r;
  dsso_pkg::offset_t left_off_r, right_off_r;

  // Tick state.
  dsso_pkg::image_t  image_r, image_nxt;
  dsso_pkg::period_t left_elapsed_r, left_elapsed_nxt;
  dsso_pkg::period_t right_elapsed_r, right_elapsed_nxt;
  logic [1:0]        left_phase_r, left_phase_nxt;
  logic [1:0]        right_phase_r, right_phase_nxt;
  logic              run_flag_r, run_flag_nxt;
  logic              press_r, press_nxt;
  logic              frame_nxt;

  // Result register.
  logic                            out_valid_r;
  logic [dsso_pkg::OUT_DATA_W-1:0] out_data_r;

  // Input fields.
  logic                        button_level;
  logic                        pin_write_valid;
  logic [dsso_pkg::PIN_W-1:0]  pin_index;
  logic                        pin_level;
  dsso_pkg::pos_t              pin_pos;
  logic                        in_acc;

  assign button_level    = in_tdata[0];
  assign pin_write_valid = in_tdata[1];
  assign pin_index       = in_tdata[6:2];
  assign pin_level       = in_tdata[7];
  assign pin_pos         = dsso_pkg::POS_W'(pin_index);

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  // Write the one-hot coil pattern at an offset, dropping bits past the image.
  function automatic dsso_pkg::image_t put_coils(dsso_pkg::image_t img,
                                                 dsso_pkg::offset_t offset,
                                                 logic [1:0] phase);
    dsso_pkg::image_t res;
    dsso_pkg::pos_t   pos;
    res = img;
    for (int k = 0; k < 4; k++) begin
      pos = dsso_pkg::POS_W'(offset) + dsso_pkg::POS_W'(k);
      if (pos < IMG_LIMIT) begin
        res[pos[dsso_pkg::IMG_IDX_W-1:0]] = (phase == 2'(k));
      end
    end
    return res;
  endfunction

  // One tick: pin write, left step, right step, then button sampling.
  always_comb begin
    dsso_pkg::period_t lp;
    dsso_pkg::period_t rp;
    logic              left_step;
    logic              right_step;

    image_nxt       = image_r;
    frame_nxt       = 1'b0;
    left_phase_nxt  = left_phase_r;
    right_phase_nxt = right_phase_r;

    if (pin_write_valid && (pin_pos < IMG_LIMIT)) begin
      image_nxt[pin_pos[dsso_pkg::IMG_IDX_W-1:0]] = pin_level;
      frame_nxt = 1'b1;
    end

    // A zero period behaves as a period of one.
    lp = (left_period_r == '0) ? dsso_pkg::PERIOD_BITS'(1) : left_period_r;
    left_step = (left_elapsed_r >= lp);
    left_elapsed_nxt = left_step ? (left_elapsed_r - lp + dsso_pkg::PERIOD_BITS'(1))
                                 : (left_elapsed_r + dsso_pkg::PERIOD_BITS'(1));
    if (left_step && run_flag_r) begin
      image_nxt      = put_coils(image_nxt, left_off_r, left_phase_r);
      left_phase_nxt = left_phase_r + 2'd1;
      frame_nxt      = 1'b1;
    end

    rp = (right_period_r == '0) ? dsso_pkg::PERIOD_BITS'(1) : right_period_r;
    right_step = (right_elapsed_r >= rp);
    right_elapsed_nxt = right_step ? (right_elapsed_r - rp + dsso_pkg::PERIOD_BITS'(1))
                                   : (right_elapsed_r + dsso_pkg::PERIOD_BITS'(1));
    if (right_step && run_flag_r) begin
      image_nxt       = put_coils(image_nxt, right_off_r, right_phase_r);
      right_phase_nxt = right_phase_r - 2'd1;
      frame_nxt       = 1'b1;
    end

    // Toggle the run flag once per press.
    run_flag_nxt = run_flag_r;
    press_nxt    = press_r;
    if (!button_level) begin
      if (!press_r) begin
        run_flag_nxt = !run_flag_r;
        press_nxt    = 1'b1;
      end
    end else begin
      press_nxt = 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_period_r  <= dsso_pkg::LEFT_PERIOD_RST;
      right_period_r <= dsso_pkg::RIGHT_PERIOD_RST;
      left_off_r     <= dsso_pkg::LEFT_OFFSET_RST;
      right_off_r    <= dsso_pkg::RIGHT_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dsso_pkg::cfg_reg_t'(cfg_index))
        dsso_pkg::REG_LEFT_PERIOD:  left_period_r  <= cfg_data;
        dsso_pkg::REG_RIGHT_PERIOD: right_period_r <= cfg_data;
        dsso_pkg::REG_LEFT_OFFSET:  left_off_r     <= cfg_data[dsso_pkg::OFFSET_W-1:0];
        dsso_pkg::REG_RIGHT_OFFSET: right_off_r    <= cfg_data[dsso_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r         <= '0;
      left_elapsed_r  <= '0;
      right_elapsed_r <= '0;
      left_phase_r    <= '0;
      right_phase_r   <= '0;
      run_flag_r      <= 1'b0;
      press_r         <= 1'b0;
    end else if (in_acc) begin
      image_r         <= image_nxt;
      left_elapsed_r  <= left_elapsed_nxt;
      right_elapsed_r <= right_elapsed_nxt;
      left_phase_r    <= left_phase_nxt;
      right_phase_r   <= right_phase_nxt;
      run_flag_r      <= run_flag_nxt;
      press_r         <= press_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= dsso_pkg::OUT_DATA_W'({run_flag_nxt, frame_nxt, image_nxt});
    end
  end

  // A disabled tick without a pin write inside the image sends no frame.
  `DSSO_ASSERT(a_no_frame_when_idle,
    in_acc && !run_flag_r && !(pin_write_valid && (pin_pos < IMG_LIMIT))
      |=> !out_data_r[dsso_pkg::IMG_BITS],
    "frame sent with motor off and no pin write")
  // Phases hold while the motor is off.
  `DSSO_ASSERT(a_phase_hold,
    in_acc && !run_flag_r |=> $stable(left_phase_r) && $stable(right_phase_r),
    "phase moved while motor disabled")
  // The reported run flag is the flag the block now holds.
  `DSSO_ASSERT(a_run_flag_report,
    in_acc |=> out_data_r[dsso_pkg::IMG_BITS+1] == run_flag_r,
    "motor_enabled does not match run flag")
  // Reset empties the result register.
  `DSSO_ASSERT_RST(a_reset_empty,
    !rst_n |=> !out_valid_r,
    "result valid after reset")

endmodule

@@ bench/stepper_image_checker.sv @@
`timescale 1ns / 1ps

module stepper_image_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [0] button_level, [1] pin_write_valid, [6:2] pin_index, [7] pin_level
  input  logic [dsso_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [23:0] output_image, [24] frame_sent, [25] motor_enabled, rest zero
  input  logic [dsso_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dsso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsso_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              waiting,
  output int                              words_checked,
  output int                              frames_seen,
  output int                              left_steps,
  output int                              right_steps,
  output int                              cfg_writes
);

  // One tick's worth of output: image, frame flag and run flag.
  typedef struct packed {
    dsso_pkg::image_t image;
    logic             frame;
    logic             enabled;
  } tick_image_t;

  tick_image_t tick_images[$];

  // Mirror of the controller state and its registers.
  dsso_pkg::image_t  image;
  dsso_pkg::period_t left_per, right_per;
  dsso_pkg::period_t left_cnt, right_cnt;
  dsso_pkg::offset_t left_off, right_off;
  logic [1:0]        left_ph, right_ph;
  logic              running;
  logic              press_held;

  // Advances one period counter. The top bit says the channel is due to step.
  // A period of zero behaves like a period of one.
  function automatic logic [dsso_pkg::PERIOD_BITS:0] count_tick(dsso_pkg::period_t cnt,
                                                                 dsso_pkg::period_t per);
    dsso_pkg::period_t eff;
    eff = (per == '0) ? dsso_pkg::period_t'(1) : per;
    if (cnt >= eff) return {1'b1, dsso_pkg::period_t'(cnt - eff + dsso_pkg::period_t'(1))};
    return {1'b0, dsso_pkg::period_t'(cnt + dsso_pkg::period_t'(1))};
  endfunction

  // Writes the one-hot coil pattern; bits past the top of the image are dropped.
  function automatic void put_coils(dsso_pkg::offset_t off, logic [1:0] ph);
    int pos;
    for (int k = 0; k < 4; k++) begin
      pos = int'(off) + k;
      if (pos < dsso_pkg::IMG_BITS) image[pos[dsso_pkg::IMG_IDX_W-1:0]] = (k == int'(ph));
    end
  endfunction

  // Works out the result of one tick and queues it.
  task automatic step_motors(input logic [dsso_pkg::IN_DATA_W-1:0] w);
    logic [dsso_pkg::PERIOD_BITS:0] lt;
    logic [dsso_pkg::PERIOD_BITS:0] rt;
    logic                           frame;
    logic                           button;
    logic                           wr;
    logic                           lvl;
    logic [dsso_pkg::PIN_W-1:0]     pin;
    {lvl, pin, wr, button} = w;
    frame = 1'b0;

    // The pin write lands first; indexes past the image are ignored.
    if (wr && (int'(pin) < dsso_pkg::IMG_BITS)) begin
      image[pin] = lvl;
      frame = 1'b1;
    end

    // Both channels use the run flag from before this tick's button sample.
    lt = count_tick(left_cnt, left_per);
    left_cnt = lt[dsso_pkg::PERIOD_BITS-1:0];
    if (lt[dsso_pkg::PERIOD_BITS] && running) begin
      put_coils(left_off, left_ph);
      left_ph = left_ph + 2'd1;
      frame = 1'b1;
      left_steps++;
    end

    rt = count_tick(right_cnt, right_per);
    right_cnt = rt[dsso_pkg::PERIOD_BITS-1:0];
    if (rt[dsso_pkg::PERIOD_BITS] && running) begin
      put_coils(right_off, right_ph);
      right_ph = right_ph - 2'd1;
      frame = 1'b1;
      right_steps++;
    end

    // A press toggles the run flag once; releasing the button re-arms it.
    if (!button) begin
      if (!press_held) begin
        running = !running;
        press_held = 1'b1;
      end
    end else begin
      press_held = 1'b0;
    end

    tick_images.push_back('{image, frame, running});
    waiting++;
  endtask

  always @(posedge clk) begin
    tick_image_t                     want;
    logic [dsso_pkg::OUT_DATA_W-1:0] got;
    if (!rst_n) begin
      image      = '0;
      left_per   = dsso_pkg::LEFT_PERIOD_RST;
      right_per  = dsso_pkg::RIGHT_PERIOD_RST;
      left_off   = dsso_pkg::LEFT_OFFSET_RST;
      right_off  = dsso_pkg::RIGHT_OFFSET_RST;
      left_cnt   = '0;
      right_cnt  = '0;
      left_ph    = '0;
      right_ph   = '0;
      running    = 1'b0;
      press_held = 1'b0;
      tick_images.delete();
      waiting = 0;
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (dsso_pkg::cfg_reg_t'(cfg_index))
          dsso_pkg::REG_LEFT_PERIOD:  left_per  = cfg_data;
          dsso_pkg::REG_RIGHT_PERIOD: right_per = cfg_data;
          dsso_pkg::REG_LEFT_OFFSET:  left_off  = cfg_data[dsso_pkg::OFFSET_W-1:0];
          dsso_pkg::REG_RIGHT_OFFSET: right_off = cfg_data[dsso_pkg::OFFSET_W-1:0];
          default: ;
        endcase
      end

      // Each accepted tick word yields exactly one result word.
      if (in_tvalid && in_tready) step_motors(in_tdata);

      // Compare each result word against the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (tick_images.size() == 0) begin
          $error("result word 0x%0h arrived with no tick outstanding", got);
          errors++;
        end else begin
          want = tick_images.pop_front();
          waiting--;
          words_checked++;
          if (got[dsso_pkg::IMG_BITS]) frames_seen++;
          if (got[dsso_pkg::IMG_BITS-1:0] !== want.image) begin
            $error("output_image: expected 0x%06h, got 0x%06h", want.image,
                   got[dsso_pkg::IMG_BITS-1:0]);
            errors++;
          end
          if (got[dsso_pkg::IMG_BITS] !== want.frame) begin
            $error("frame_sent: expected %0b, got %0b", want.frame,
                   got[dsso_pkg::IMG_BITS]);
            errors++;
          end
          if (got[dsso_pkg::IMG_BITS+1] !== want.enabled) begin
            $error("motor_enabled: expected %0b, got %0b", want.enabled,
                   got[dsso_pkg::IMG_BITS+1]);
            errors++;
          end
          if (got[dsso_pkg::OUT_DATA_W-1:dsso_pkg::OUT_FIELD_W] !== '0) begin
            $error("padding: expected 0, got 0x%0h",
                   got[dsso_pkg::OUT_DATA_W-1:dsso_pkg::OUT_FIELD_W]);
            errors++;
          end
        end
      end
    end
  end

endmodule

@@ bench/tb_dual_stepper_shift_output.sv @@
`timescale 1ns / 1ps

module tb_dual_stepper_shift_output;

  localparam int TIMEOUT_NS  = 5_000_000;
  localparam int HOLD_EVERY  = 1500;
  localparam int HOLD_CYCLES = 240;
  localparam int SETTLE_MAX  = 20000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [dsso_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [dsso_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dsso_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dsso_pkg::CFG_DATA_W-1:0] cfg_data;

  int errors;
  int waiting;
  int words_checked;
  int frames_seen;
  int left_steps;
  int right_steps;
  int cfg_writes;

  dual_stepper_shift_output dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  stepper_image_checker image_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .waiting       (waiting),
    .words_checked (words_checked),
    .frames_seen   (frames_seen),
    .left_steps    (left_steps),
    .right_steps   (right_steps),
    .cfg_writes    (cfg_writes)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the handshakes hang.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Result side: random stall patterns in segments, plus a long hold-off
  // at regular intervals so the block backs up into its input.
  initial begin : result_stalls
    int cyc;
    int seg_left;
    int mode;
    cyc = 0;
    seg_left = 0;
    mode = 0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % HOLD_EVERY == 0) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        cyc += HOLD_CYCLES;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Packs one tick word.
  function automatic logic [dsso_pkg::IN_DATA_W-1:0] tick_word(
      logic button, logic wr, logic [dsso_pkg::PIN_W-1:0] pin, logic lvl);
    return {lvl, pin, wr, button};
  endfunction

  // Button mostly released, half the ticks carry a pin write, any index.
  function automatic logic [dsso_pkg::IN_DATA_W-1:0] random_tick();
    return tick_word($urandom_range(0, 11) != 0, 1'($urandom_range(0, 1)),
                     dsso_pkg::PIN_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
  endfunction

  // Offers one word and returns at the falling edge after it is taken.
  task automatic send_tick(input logic [dsso_pkg::IN_DATA_W-1:0] w);
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Random ticks in bursts; some bursts run back to back with no gap.
  task automatic run_ticks(input int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) burst = $urandom_range(1, 24);
      send_tick(random_tick());
      burst--;
      if (burst == 0 && $urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // Waits until every predicted word has come back, or until the guard runs out.
  task automatic settle();
    int guard;
    guard = 0;
    while (waiting != 0 && guard < SETTLE_MAX) begin
      @(negedge clk);
      guard++;
    end
    repeat (3) @(negedge clk);
  endtask

  // One register write; cfg_valid is handled by the caller.
  task automatic cfg_beat(input dsso_pkg::cfg_reg_t idx, input dsso_pkg::period_t val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes all four registers back to back.
  task automatic program_regs(input dsso_pkg::period_t lp, input dsso_pkg::period_t rp,
                              input dsso_pkg::offset_t lo, input dsso_pkg::offset_t ro);
    cfg_valid <= 1'b1;
    cfg_beat(dsso_pkg::REG_LEFT_PERIOD, lp);
    cfg_beat(dsso_pkg::REG_RIGHT_PERIOD, rp);
    cfg_beat(dsso_pkg::REG_LEFT_OFFSET, dsso_pkg::period_t'(lo));
    cfg_beat(dsso_pkg::REG_RIGHT_OFFSET, dsso_pkg::period_t'(ro));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= dsso_pkg::REG_LEFT_PERIOD;
    cfg_data  <= '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Pin writes at both ends of the image and past it, then button handling,
    // all under the power-up settings.
    send_tick(tick_word(1'b1, 1'b0, 5'd0, 1'b0));
    send_tick(tick_word(1'b1, 1'b1, 5'd0, 1'b1));
    send_tick(tick_word(1'b1, 1'b1, 5'd23, 1'b1));
    send_tick(tick_word(1'b1, 1'b1, 5'd24, 1'b1));
    send_tick(tick_word(1'b1, 1'b1, 5'd31, 1'b1));
    send_tick(tick_word(1'b1, 1'b0, 5'd5, 1'b1));
    send_tick(tick_word(1'b1, 1'b1, 5'd23, 1'b0));
    send_tick(tick_word(1'b0, 1'b0, 5'd0, 1'b0));
    send_tick(tick_word(1'b0, 1'b0, 5'd0, 1'b0));
    send_tick(tick_word(1'b1, 1'b0, 5'd0, 1'b0));
    send_tick(tick_word(1'b0, 1'b1, 5'd12, 1'b1));
    send_tick(tick_word(1'b1, 1'b1, 5'd0, 1'b0));
    send_tick(tick_word(1'b1, 1'b1, 5'd17, 1'b1));
    send_tick(tick_word(1'b0, 1'b0, 5'd0, 1'b0));
    send_tick(tick_word(1'b1, 1'b0, 5'd31, 1'b0));
    send_tick(tick_word(1'b0, 1'b1, 5'd8, 1'b0));
    in_tvalid <= 1'b0;

    // Fixed settings first: zero and maximum periods, offsets at and past the
    // top of the image, then periods cut below the running counts.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: program_regs(dsso_pkg::period_t'(0), dsso_pkg::period_t'(1),
                        dsso_pkg::offset_t'(0), dsso_pkg::offset_t'(20));
        1: program_regs({dsso_pkg::PERIOD_BITS{1'b1}}, dsso_pkg::period_t'(2),
                        dsso_pkg::offset_t'(31), dsso_pkg::offset_t'(21));
        2: program_regs(dsso_pkg::period_t'(40), {dsso_pkg::PERIOD_BITS{1'b1}},
                        dsso_pkg::offset_t'(22), dsso_pkg::offset_t'(3));
        3: program_regs(dsso_pkg::period_t'(3), dsso_pkg::period_t'(1),
                        dsso_pkg::offset_t'(12), dsso_pkg::offset_t'(8));
        default: program_regs(dsso_pkg::period_t'($urandom_range(0, 24)),
                              dsso_pkg::period_t'($urandom_range(1, 24)),
                              dsso_pkg::offset_t'($urandom_range(0, 31)),
                              dsso_pkg::offset_t'($urandom_range(0, 31)));
      endcase
      run_ticks((ph == 1) ? 150 : ((ph == 0 || ph == 2) ? 250 : 200));
    end

    settle();
    if (waiting != 0) $error("%0d predicted result words never arrived", waiting);
    $display("summary: %0d result words checked, %0d frames, %0d left and %0d right coil steps",
             words_checked, frames_seen, left_steps, right_steps);
    $display("summary: %0d register writes over 9 settings, %0d mismatches",
             cfg_writes, errors);
    if (errors == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
